// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker module of the sorted table unit.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while the reset argument is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Clocked property that is checked through reset as well.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

// ----- hdl/sist_pkg.sv -----
// Package for the sorted integer set table: widths, command and status codes,
// and the control/status structs between controller and datapath. No dependencies.
package sist_pkg;

   localparam int DATA_W           = 32;
   localparam int CMD_W            = 3;
   localparam int STATUS_W         = 3;
   localparam int CAPACITY_DEFAULT = 32;

   // command codes on the request side
   localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE_MIN = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE_MAX = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REMOVE_VAL = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ_OUT   = 3'd5;

   // status codes on the response side
   localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   typedef enum logic [2:0] {
      IDX_HOLD, IDX_ZERO, IDX_COUNT, IDX_INC, IDX_DEC
   } idx_op_type;

   typedef enum logic [1:0] {
      RD_IDX, RD_IDX_M1, RD_IDX_P1, RD_LAST
   } rd_sel_type;

   typedef enum logic [0:0] {
      WR_VALUE, WR_RDATA
   } wr_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD, CNT_INC, CNT_DEC
   } cnt_op_type;

   typedef enum logic [1:0] {
      RES_HOLD, RES_RDATA, RES_VALUE
   } res_op_type;

   typedef enum logic [0:0] {
      RSP_SRC_RESULT, RSP_SRC_RDATA
   } rsp_src_type;

   // controller -> datapath
   typedef struct packed {
      logic                load_req;
      idx_op_type          idx_op;
      logic                rd_en;
      rd_sel_type          rd_sel;
      logic                wr_en;
      wr_sel_type          wr_sel;
      cnt_op_type          cnt_op;
      res_op_type          res_op;
      logic                rsp_load;
      logic [STATUS_W-1:0] rsp_status;
      rsp_src_type         rsp_src;
      logic                rsp_last;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             count_zero;
      logic             count_full;
      logic             idx_zero;
      logic             idx_at_count;
      logic             idx_last;
      logic             rd_less;
      logic             rd_equal;
      logic             rsp_free;
   } dp_stat_type;

endpackage

// ----- hdl/sist_ctrl.sv -----
// Controller of the sorted integer set table: one-hot state machine that walks
// the entry memory one step at a time. Depends on sist_pkg.
module sist_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sist_pkg::dp_stat_type stat,
   output sist_pkg::dp_cmd_type  cmd
);
   import sist_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE       = 14'b00000000000001,
      S_DECODE     = 14'b00000000000010,
      S_INS_TEST   = 14'b00000000000100,
      S_INS_EVAL   = 14'b00000000001000,
      S_SRCH_TEST  = 14'b00000000010000,
      S_SRCH_EVAL  = 14'b00000000100000,
      S_MIN_RD     = 14'b00000001000000,
      S_MIN_EVAL   = 14'b00000010000000,
      S_SHIFT_TEST = 14'b00000100000000,
      S_SHIFT_EVAL = 14'b00001000000000,
      S_MAX_EVAL   = 14'b00010000000000,
      S_OUT_RD     = 14'b00100000000000,
      S_OUT_EMIT   = 14'b01000000000000,
      S_RESP       = 14'b10000000000000
   } state_type;

   state_type           state_ff, state_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      cmd       = '0;
      cmd.idx_op     = IDX_HOLD;
      cmd.rd_sel     = RD_IDX;
      cmd.wr_sel     = WR_VALUE;
      cmd.cnt_op     = CNT_HOLD;
      cmd.res_op     = RES_HOLD;
      cmd.rsp_status = ST_DONE;
      cmd.rsp_src    = RSP_SRC_RESULT;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.cmd)
               CMD_INSERT: begin
                  if (stat.count_full) begin
                     status_in = ST_FULL;
                     state_in  = S_RESP;
                  end else begin
                     cmd.idx_op = IDX_COUNT;
                     state_in   = S_INS_TEST;
                  end
               end
               CMD_SEARCH: begin
                  cmd.idx_op = IDX_ZERO;
                  state_in   = S_SRCH_TEST;
               end
               CMD_REMOVE_MIN, CMD_REMOVE_MAX, CMD_REMOVE_VAL, CMD_READ_OUT: begin
                  if (stat.count_zero) begin
                     status_in = ST_EMPTY;
                     state_in  = S_RESP;
                  end else begin
                     cmd.idx_op = IDX_ZERO;
                     case (stat.cmd)
                        CMD_REMOVE_MIN: state_in = S_MIN_RD;
                        CMD_REMOVE_VAL: state_in = S_SRCH_TEST;
                        CMD_READ_OUT:   state_in = S_OUT_RD;
                        default: begin
                           // remove largest reads the top entry right away
                           cmd.rd_en  = 1'b1;
                           cmd.rd_sel = RD_LAST;
                           state_in   = S_MAX_EVAL;
                        end
                     endcase
                  end
               end
               default: state_in = S_IDLE;   // unused codes give no result
            endcase
         end
         // insert: walk down from the top, moving entries not below the value up
         S_INS_TEST: begin
            if (stat.idx_zero) begin
               cmd.wr_en  = 1'b1;
               cmd.cnt_op = CNT_INC;
               status_in  = ST_DONE;
               state_in   = S_RESP;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX_M1;
               state_in   = S_INS_EVAL;
            end
         end
         S_INS_EVAL: begin
            cmd.wr_en = 1'b1;
            if (stat.rd_less) begin
               cmd.cnt_op = CNT_INC;
               status_in  = ST_DONE;
               state_in   = S_RESP;
            end else begin
               cmd.wr_sel = WR_RDATA;
               cmd.idx_op = IDX_DEC;
               state_in   = S_INS_TEST;
            end
         end
         // search / remove value: walk up looking for an equal entry
         S_SRCH_TEST: begin
            if (stat.idx_at_count) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_RESP;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_SRCH_EVAL;
            end
         end
         S_SRCH_EVAL: begin
            if (stat.rd_equal) begin
               if (stat.cmd == CMD_SEARCH) begin
                  status_in = ST_FOUND;
                  state_in  = S_RESP;
               end else begin
                  cmd.res_op = RES_VALUE;
                  state_in   = S_SHIFT_TEST;
               end
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = S_SRCH_TEST;
            end
         end
         // remove smallest: take entry zero, then close the gap
         S_MIN_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_MIN_EVAL;
         end
         S_MIN_EVAL: begin
            cmd.res_op = RES_RDATA;
            state_in   = S_SHIFT_TEST;
         end
         // close the gap at idx by moving higher entries down one place
         S_SHIFT_TEST: begin
            if (stat.idx_last) begin
               cmd.cnt_op = CNT_DEC;
               status_in  = ST_DONE;
               state_in   = S_RESP;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX_P1;
               state_in   = S_SHIFT_EVAL;
            end
         end
         S_SHIFT_EVAL: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_RDATA;
            cmd.idx_op = IDX_INC;
            state_in   = S_SHIFT_TEST;
         end
         S_MAX_EVAL: begin
            cmd.res_op = RES_RDATA;
            cmd.cnt_op = CNT_DEC;
            status_in  = ST_DONE;
            state_in   = S_RESP;
         end
         // read-out: one item per entry, the last one marked
         S_OUT_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_OUT_EMIT;
         end
         S_OUT_EMIT: begin
            if (stat.rsp_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_DONE;
               cmd.rsp_src    = RSP_SRC_RDATA;
               cmd.rsp_last   = stat.idx_last;
               if (stat.idx_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_op = IDX_INC;
                  state_in   = S_OUT_RD;
               end
            end
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = status_ff;
               cmd.rsp_last   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // pending status, payload only
   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

endmodule

// ----- hdl/sist_dp.sv -----
// Datapath of the sorted integer set table: entry memory, walk index, entry
// count, compare logic and the response register. Depends on sist_pkg.
module sist_dp #(
   parameter int CAPACITY = sist_pkg::CAPACITY_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [sist_pkg::CMD_W-1:0]          req_cmd,
   input  logic signed [sist_pkg::DATA_W-1:0]  req_value,
   input  sist_pkg::dp_cmd_type                cmd,
   output sist_pkg::dp_stat_type               stat,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [sist_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [sist_pkg::DATA_W-1:0]  rsp_value,
   output logic                                rsp_last
);
   import sist_pkg::*;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);

   logic [DATA_W-1:0]        entry_mem [CAPACITY];
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [CMD_W-1:0]         cmd_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] result_ff;
   logic [DATA_W-1:0]        rdata_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic                     rsp_last_ff;

   logic [CNT_W-1:0]         idx_m1, idx_p1, count_m1, rd_ptr;
   logic [ADDR_W-1:0]        rd_addr, wr_addr;
   logic [DATA_W-1:0]        wr_data;

   assign idx_m1   = idx_ff - CNT_W'(1);
   assign idx_p1   = idx_ff + CNT_W'(1);
   assign count_m1 = count_ff - CNT_W'(1);

   // read and write addresses
   always_comb begin
      case (cmd.rd_sel)
         RD_IDX_M1: rd_ptr = idx_m1;
         RD_IDX_P1: rd_ptr = idx_p1;
         RD_LAST:   rd_ptr = count_m1;
         default:   rd_ptr = idx_ff;
      endcase
   end
   assign rd_addr = rd_ptr[ADDR_W-1:0];
   assign wr_addr = idx_ff[ADDR_W-1:0];
   assign wr_data = (cmd.wr_sel == WR_RDATA) ? rdata_ff : value_ff;

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= entry_mem[rd_addr];
      end
   end

   // index and count
   always_comb begin
      case (cmd.idx_op)
         IDX_ZERO:  idx_in = '0;
         IDX_COUNT: idx_in = count_ff;
         IDX_INC:   idx_in = idx_p1;
         IDX_DEC:   idx_in = idx_m1;
         default:   idx_in = idx_ff;
      endcase
      case (cmd.cnt_op)
         CNT_INC: count_in = count_ff + CNT_W'(1);
         CNT_DEC: count_in = count_m1;
         default: count_in = count_ff;
      endcase
   end

   // response register valid
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff   <= req_cmd;
         value_ff <= req_value;
      end
      if (cmd.load_req) begin
         result_ff <= '0;
      end else if (cmd.res_op == RES_RDATA) begin
         result_ff <= rdata_ff;
      end else if (cmd.res_op == RES_VALUE) begin
         result_ff <= value_ff;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_value_ff  <= (cmd.rsp_src == RSP_SRC_RDATA) ? rdata_ff : result_ff;
         rsp_last_ff   <= cmd.rsp_last;
      end
   end

   // status to the controller
   always_comb begin
      stat.cmd          = cmd_ff;
      stat.count_zero   = (count_ff == '0);
      stat.count_full   = (count_ff == CNT_W'(CAPACITY));
      stat.idx_zero     = (idx_ff == '0);
      stat.idx_at_count = (idx_ff == count_ff);
      stat.idx_last     = (idx_p1 == count_ff);
      stat.rd_less      = ($signed(rdata_ff) < value_ff);
      stat.rd_equal     = (rdata_ff == value_ff);
      stat.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ----- hdl/sorted_integer_set_table_unit.sv -----
// Sorted integer set table, top level: one command at a time, each memory step
// sets an address, then uses the registered read data. Insert, search and the
// removals walk the entries one step at a time; remove largest reads the top entry directly.
// Read-out gives one item per entry; an item waits while the output is held.
// A new command is taken once all items of the previous one are in the output register.
// Synchronous active-high reset empties the table; entry storage itself is not cleared.
module sorted_integer_set_table_unit #(
   parameter int CAPACITY = sist_pkg::CAPACITY_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic signed [sist_pkg::DATA_W-1:0]  req_tdata,  // [31:0] operand_value
   input  logic [sist_pkg::CMD_W-1:0]          req_tuser,  // [2:0] cmd
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic signed [sist_pkg::DATA_W-1:0]  rsp_tdata,  // [31:0] result_value
   output logic [sist_pkg::STATUS_W-1:0]       rsp_tuser,  // [2:0] status
   output logic                                rsp_tlast   // last_of_run
);
   import sist_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   sist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   sist_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_cmd    (req_tuser),
      .req_value  (req_tdata),
      .cmd        (dp_cmd),
      .stat       (dp_stat),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_status (rsp_tuser),
      .rsp_value  (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

endmodule

// ----- hdl/sist_checker.sv -----
// Port-level checks for the sorted integer set table, bound to the top level.
// Depends on sist_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sist_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic signed [sist_pkg::DATA_W-1:0]  rsp_tdata,
   input logic [sist_pkg::STATUS_W-1:0]       rsp_tuser,
   input logic                                rsp_tlast
);
   import sist_pkg::*;

   // a held item keeps its payload
   `ASSERT_CLK(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable({rsp_tdata, rsp_tuser, rsp_tlast}))

   // reset leaves no result pending
   `ASSERT_CLK_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid)

   // one command at a time: taking a command closes the input for the next cycle
   `ASSERT_CLK(a_one_cmd, clock, reset, req_tvalid && req_tready |=> !req_tready)

   // items before the end of a run are read-out entries: done, input closed
   `ASSERT_CLK(a_run_body, clock, reset,
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == ST_DONE && !req_tready)

endmodule

bind sorted_integer_set_table_unit sist_checker u_sist_checker (.*);
